[sv/lsf_pkg.sv]
// Shared constants, types and a helper function of the line substring filter.
`timescale 1ns / 1ps
`default_nettype none

package lsf_pkg;

   // Default depth of the pattern store and of the recent text window.
   localparam int LSF_PATTERN_MAX = 64;

   // Field widths fixed by the interface.
   localparam int CMD_W      = 2;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 6;
   localparam int POS_COUNT  = 1 << POS_W;
   localparam int LINE_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

   // Internal operations after classification.
   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_TEXT     = 2'd1;
   localparam logic [1:0] OP_LINE_END = 2'd2;
   localparam logic [1:0] OP_TEXT_END = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CASE_FOLD      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_SEL     = 2'd2;

   // Special byte values.
   localparam logic [BYTE_W-1:0] NEWLINE_BYTE  = 8'h0A;
   localparam logic [BYTE_W-1:0] NUL_BYTE      = 8'h00;
   localparam logic [BYTE_W-1:0] UPPER_A_BYTE  = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_Z_BYTE  = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_DISTANCE = 8'h20;

   // Configuration register set.
   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_length;
      logic                  case_fold;
      logic                  invert_sel;
   } lsf_cfg_type;

   // One classified item in the queue between front and back.
   typedef struct packed {
      logic [1:0]        op;
      logic [BYTE_W-1:0] byte_value;
      logic [POS_W-1:0]  position;
   } lsf_item_type;

   // Control handed from the match stage to the report stage.
   typedef struct packed {
      logic [1:0] op;
      logic       nonempty;
      logic       window_ok;
      logic       empty_pattern;
   } lsf_step_type;

   // ASCII fold of upper case to lower case when enabled.
   function automatic logic [BYTE_W-1:0] lsf_fold(input logic [BYTE_W-1:0] c,
                                                  input logic fold_en);
      logic [BYTE_W-1:0] r;
      r = c;
      if (fold_en && (c >= UPPER_A_BYTE) && (c <= UPPER_Z_BYTE)) begin
         r = c + CASE_DISTANCE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/lsf_front.sv]
// Front end: accepts request transfers and classifies them into queue items.
`timescale 1ns / 1ps
`default_nettype none

module lsf_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lsf_pkg::CMD_W-1:0]  req_cmd,
   input  logic [lsf_pkg::BYTE_W-1:0] req_byte_value,
   input  logic [lsf_pkg::POS_W-1:0]  req_pattern_position,
   input  logic                       queue_full,
   output logic                       push_valid,
   output lsf_pkg::lsf_item_type      push_item
);

   logic keep;

   // The queue decides whether a transfer can be taken.
   assign req_ready = !queue_full;

   // Decode the command; a zero text byte behaves as end of text, unused codes drop.
   always_comb begin
      keep                 = 1'b1;
      push_item.op         = lsf_pkg::OP_LOAD;
      push_item.byte_value = req_byte_value;
      push_item.position   = req_pattern_position;
      case (req_cmd)
         lsf_pkg::CMD_LOAD: begin
            push_item.op = lsf_pkg::OP_LOAD;
         end
         lsf_pkg::CMD_TEXT: begin
            if (req_byte_value == lsf_pkg::NUL_BYTE) begin
               push_item.op = lsf_pkg::OP_TEXT_END;
            end else if (req_byte_value == lsf_pkg::NEWLINE_BYTE) begin
               push_item.op = lsf_pkg::OP_LINE_END;
            end else begin
               push_item.op = lsf_pkg::OP_TEXT;
            end
         end
         lsf_pkg::CMD_END: begin
            push_item.op = lsf_pkg::OP_TEXT_END;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push_valid = req_valid && req_ready && keep;

endmodule

`default_nettype wire

[sv/lsf_queue.sv]
// Two-entry queue that decouples the front end from the match engine.
`timescale 1ns / 1ps
`default_nettype none

module lsf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lsf_pkg::lsf_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output lsf_pkg::lsf_item_type head_item
);

   lsf_pkg::lsf_item_type slot_ff [2];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;
   logic                  do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Storage is written at the tail; no reset needed on the payload.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!push_valid && do_pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

[sv/lsf_match.sv]
// Match engine: pattern store, recent text window and per-lane byte compare.
`timescale 1ns / 1ps
`default_nettype none

module lsf_match #(
   parameter int PATTERN_MAX = lsf_pkg::LSF_PATTERN_MAX
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lsf_pkg::lsf_cfg_type     cfg,
   input  logic                     head_valid,
   input  lsf_pkg::lsf_item_type    head_item,
   output logic                     head_pop,
   output logic                     step_valid,
   input  logic                     step_ready,
   output lsf_pkg::lsf_step_type    step,
   output logic [PATTERN_MAX-1:0]   lane_ok
);

   localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW = $clog2(PATTERN_MAX + 1);

   logic [lsf_pkg::BYTE_W-1:0] pattern_ff [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]     zero_ff;
   logic [lsf_pkg::BYTE_W-1:0] window_ff [PATTERN_MAX];
   logic [lsf_pkg::BYTE_W-1:0] shifted [PATTERN_MAX];
   logic [lsf_pkg::BYTE_W-1:0] folded_win [PATTERN_MAX];
   logic [LW:0]                pick [PATTERN_MAX];
   logic [LW-1:0]              count_ff;
   logic [LW-1:0]              count_sat;
   logic [LW-1:0]              eff_len_ff;
   logic [LW-1:0]              eff_len_in;
   logic [LW-1:0]              clamp;
   logic [LW-1:0]              zero_pos;
   logic [PATTERN_MAX-1:0]     zero_mask;
   logic [PATTERN_MAX-1:0]     zero_low;
   logic [IW-1:0]              store_idx;
   logic                       guard_ff;
   logic                       fire;
   logic                       step_valid_ff;
   lsf_pkg::lsf_step_type      step_ff;
   lsf_pkg::lsf_step_type      step_in;
   logic [PATTERN_MAX-1:0]     lane_ok_ff;
   logic [PATTERN_MAX-1:0]     lane_ok_in;

   // An item executes when the stage ahead has room; a pattern write blocks
   // the next cycle so that the effective length has settled.
   assign fire     = head_valid && !guard_ff && (!step_valid_ff || step_ready);
   assign head_pop = fire;

   // Pattern position wraps at the store depth.
   always_comb begin
      store_idx = '0;
      for (int k = 0; k < lsf_pkg::POS_COUNT; k++) begin
         if (head_item.position == lsf_pkg::POS_W'(k)) begin
            store_idx = IW'(k % PATTERN_MAX);
         end
      end
   end

   // Effective length: configured length clamped to the depth, cut at the first zero byte.
   always_comb begin
      if (int'(cfg.pattern_length) > PATTERN_MAX) begin
         clamp = LW'(PATTERN_MAX);
      end else begin
         clamp = LW'(cfg.pattern_length);
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         zero_mask[i] = zero_ff[i] && (LW'(i) < clamp);
      end
      zero_low = zero_mask & (~zero_mask + PATTERN_MAX'(1));
      zero_pos = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (zero_low[i]) begin
            zero_pos = zero_pos | LW'(i);
         end
      end
      eff_len_in = (zero_mask == '0) ? clamp : zero_pos;
   end

   // Window as it stands after the incoming text byte, newest byte at the top.
   always_comb begin
      for (int j = 0; j < PATTERN_MAX - 1; j++) begin
         shifted[j] = window_ff[j + 1];
      end
      shifted[PATTERN_MAX-1] = head_item.byte_value;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         folded_win[j] = lsf_pkg::lsf_fold(shifted[j], cfg.case_fold);
      end
   end

   assign count_sat = (count_ff == LW'(PATTERN_MAX)) ? count_ff : count_ff + LW'(1);

   // Lane i lines pattern byte i up with the window byte that ends the match at the newest byte.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pick[i]       = (LW + 1)'(PATTERN_MAX) - {1'b0, eff_len_ff} + (LW + 1)'(i);
         lane_ok_in[i] = (LW'(i) >= eff_len_ff) ||
                         (folded_win[pick[i][IW-1:0]] ==
                          lsf_pkg::lsf_fold(pattern_ff[i], cfg.case_fold));
      end
   end

   // Control that the report stage needs for this item.
   always_comb begin
      step_in.op            = head_item.op;
      step_in.nonempty      = (count_ff != '0);
      step_in.window_ok     = (eff_len_ff != '0) && (count_sat >= eff_len_ff);
      step_in.empty_pattern = (eff_len_ff == '0);
   end

   // Pattern store; entries are only meaningful once written.
   always_ff @(posedge clock) begin
      if (fire && (head_item.op == lsf_pkg::OP_LOAD)) begin
         pattern_ff[store_idx] <= head_item.byte_value;
      end
   end

   // Zero flags of the pattern store, clear after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= '0;
      end else if (fire && (head_item.op == lsf_pkg::OP_LOAD)) begin
         zero_ff[store_idx] <= (head_item.byte_value == lsf_pkg::NUL_BYTE);
      end
   end

   // Text window shifts on each text byte; bytes beyond the line count are never compared.
   always_ff @(posedge clock) begin
      if (fire && (head_item.op == lsf_pkg::OP_TEXT)) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            window_ff[j] <= shifted[j];
         end
      end
   end

   // Line byte count, effective length and the write guard.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         eff_len_ff <= '0;
         guard_ff   <= 1'b0;
      end else begin
         eff_len_ff <= eff_len_in;
         guard_ff   <= fire && (head_item.op == lsf_pkg::OP_LOAD);
         if (fire) begin
            if (head_item.op == lsf_pkg::OP_TEXT) begin
               count_ff <= count_sat;
            end else if (head_item.op != lsf_pkg::OP_LOAD) begin
               count_ff <= '0;
            end
         end
      end
   end

   // Stage register toward the report stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff <= 1'b0;
      end else if (!step_valid_ff || step_ready) begin
         step_valid_ff <= fire && (head_item.op != lsf_pkg::OP_LOAD);
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         step_ff    <= step_in;
         lane_ok_ff <= lane_ok_in;
      end
   end

   assign step_valid = step_valid_ff;
   assign step       = step_ff;
   assign lane_ok    = lane_ok_ff;

endmodule

`default_nettype wire

[sv/lsf_report.sv]
// Report stage: line match flag, line counter and the response register.
`timescale 1ns / 1ps
`default_nettype none

module lsf_report #(
   parameter int PATTERN_MAX = lsf_pkg::LSF_PATTERN_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       invert_sel,
   input  logic                       step_valid,
   output logic                       step_ready,
   input  lsf_pkg::lsf_step_type      step,
   input  logic [PATTERN_MAX-1:0]     lane_ok,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [lsf_pkg::LINE_W-1:0] rsp_line_number,
   output logic                       rsp_contains_pattern,
   output logic                       rsp_selected
);

   logic                       line_hit_ff;
   logic [lsf_pkg::LINE_W-1:0] line_count_ff;
   logic                       rsp_valid_ff;
   logic [lsf_pkg::LINE_W-1:0] rsp_line_number_ff;
   logic                       rsp_contains_ff;
   logic                       rsp_selected_ff;
   logic                       is_end;
   logic                       emits;
   logic                       out_free;
   logic                       take;
   logic                       hit_now;
   logic                       line_contains;

   // A finished non-empty line needs the response register free.
   assign is_end        = (step.op == lsf_pkg::OP_LINE_END) ||
                          (step.op == lsf_pkg::OP_TEXT_END);
   assign emits         = is_end && step.nonempty;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign step_ready    = !emits || out_free;
   assign take          = step_valid && step_ready;
   assign hit_now       = step.window_ok && (&lane_ok);
   assign line_contains = line_hit_ff || step.empty_pattern;

   // Line state: match flag and saturating line counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_hit_ff   <= 1'b0;
         line_count_ff <= lsf_pkg::LINE_W'(1);
      end else if (take) begin
         case (step.op)
            lsf_pkg::OP_TEXT: begin
               if (hit_now) begin
                  line_hit_ff <= 1'b1;
               end
            end
            lsf_pkg::OP_LINE_END: begin
               line_hit_ff <= 1'b0;
               if (step.nonempty && (line_count_ff != '1)) begin
                  line_count_ff <= line_count_ff + lsf_pkg::LINE_W'(1);
               end
            end
            lsf_pkg::OP_TEXT_END: begin
               line_hit_ff   <= 1'b0;
               line_count_ff <= lsf_pkg::LINE_W'(1);
            end
            default: begin
               line_hit_ff <= line_hit_ff;
            end
         endcase
      end
   end

   // Response register; it frees as soon as the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= take && emits;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emits) begin
         rsp_line_number_ff <= line_count_ff;
         rsp_contains_ff    <= line_contains;
         rsp_selected_ff    <= line_contains ^ invert_sel;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_number      = rsp_line_number_ff;
   assign rsp_contains_pattern = rsp_contains_ff;
   assign rsp_selected         = rsp_selected_ff;

endmodule

`default_nettype wire

[sv/line_substring_filter.sv]
// Top level of the line substring filter: configuration registers and the pipeline.
// With the pipeline empty, a newline or end transfer passes the queue, the match stage and the
// response register before rsp_valid rises. Throughput: one transfer per cycle while the queue
// has room; each pattern byte load stalls the match engine while the effective length settles.
// Reset is synchronous; afterwards the pattern length is zero, both flags are clear,
// the line counter is one and the pattern store holds nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none

module line_substring_filter #(
   parameter int PATTERN_MAX = lsf_pkg::LSF_PATTERN_MAX
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lsf_pkg::CMD_W-1:0]      req_cmd,
   input  logic [lsf_pkg::BYTE_W-1:0]     req_byte_value,
   input  logic [lsf_pkg::POS_W-1:0]      req_pattern_position,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lsf_pkg::LINE_W-1:0]     rsp_line_number,
   output logic                           rsp_contains_pattern,
   output logic                           rsp_selected,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsf_pkg::CSR_DATA_W-1:0] csr_data
);

   lsf_pkg::lsf_cfg_type   cfg_ff;
   logic                   queue_full;
   logic                   push_valid;
   lsf_pkg::lsf_item_type  push_item;
   logic                   head_pop;
   logic                   head_valid;
   lsf_pkg::lsf_item_type  head_item;
   logic                   step_valid;
   logic                   step_ready;
   lsf_pkg::lsf_step_type  step;
   logic [PATTERN_MAX-1:0] lane_ok;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_length <= '0;
         cfg_ff.case_fold      <= 1'b0;
         cfg_ff.invert_sel     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lsf_pkg::REG_PATTERN_LENGTH: begin
               cfg_ff.pattern_length <= csr_data;
            end
            lsf_pkg::REG_CASE_FOLD: begin
               cfg_ff.case_fold <= csr_data[0];
            end
            lsf_pkg::REG_INVERT_SEL: begin
               cfg_ff.invert_sel <= csr_data[0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Request classification.
   lsf_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_byte_value       (req_byte_value),
      .req_pattern_position (req_pattern_position),
      .queue_full           (queue_full),
      .push_valid           (push_valid),
      .push_item            (push_item)
   );

   // Decoupling queue.
   lsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Pattern and window compare.
   lsf_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .step_valid (step_valid),
      .step_ready (step_ready),
      .step       (step),
      .lane_ok    (lane_ok)
   );

   // Line bookkeeping and response.
   lsf_report #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_report (
      .clock                (clock),
      .reset                (reset),
      .invert_sel           (cfg_ff.invert_sel),
      .step_valid           (step_valid),
      .step_ready           (step_ready),
      .step                 (step),
      .lane_ok              (lane_ok),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_line_number      (rsp_line_number),
      .rsp_contains_pattern (rsp_contains_pattern),
      .rsp_selected         (rsp_selected)
   );

endmodule

`default_nettype wire

[sv/lsf_checker.sv]
// Port-level checks of the line substring filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lsf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [lsf_pkg::LINE_W-1:0] rsp_line_number,
   input logic                       rsp_contains_pattern,
   input logic                       rsp_selected
);

   // Reset empties the pipeline: no response, room for requests.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("response pending or request side blocked after reset");

   // Line numbers count from one.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0))
      else $error("response carries line number zero");

   // A stalled response keeps its transfer pending.
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before its transfer");

   // A stalled response keeps its payload.
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_line_number) && $stable(rsp_contains_pattern) &&
          $stable(rsp_selected)))
      else $error("response payload changed while stalled");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_line_number      (rsp_line_number),
   .rsp_contains_pattern (rsp_contains_pattern),
   .rsp_selected         (rsp_selected)
);

`default_nettype wire

[test/line_substring_filter_tb.sv]
// Self-checking testbench for the line substring filter: directed table, then random lines.
`timescale 1ns / 1ps

module line_substring_filter_tb;

   typedef logic [lsf_pkg::CMD_W-1:0]      cmd_type;
   typedef logic [lsf_pkg::BYTE_W-1:0]     byte_type;
   typedef logic [lsf_pkg::POS_W-1:0]      pos_type;
   typedef logic [lsf_pkg::LINE_W-1:0]     line_type;
   typedef logic [lsf_pkg::CSR_IDX_W-1:0]  idx_type;
   typedef logic [lsf_pkg::CSR_DATA_W-1:0] data_type;

   localparam int PATTERN_DEPTH = lsf_pkg::LSF_PATTERN_MAX;
   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 10;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS = 180;
   localparam longint CYCLE_LIMIT = 1000000;

   // One finished line as the block reports it.
   typedef struct {
      line_type line_number;
      logic     contains;
      logic     selected;
   } line_report_type;

   // One row of the directed table: a request transfer or a register write.
   typedef struct {
      bit              is_reg;
      cmd_type         cmd;
      byte_type        value;
      pos_type         pos;
      idx_type         reg_idx;
      data_type        reg_val;
      bit              typed;
      line_report_type typed_report;
   } stim_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   cmd_type  req_cmd = lsf_pkg::CMD_LOAD;
   byte_type req_byte_value = '0;
   pos_type  req_pattern_position = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   line_type rsp_line_number;
   logic     rsp_contains_pattern;
   logic     rsp_selected;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   idx_type  csr_index = lsf_pkg::REG_PATTERN_LENGTH;
   data_type csr_data = '0;

   line_substring_filter DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_byte_value      (req_byte_value),
      .req_pattern_position(req_pattern_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_number     (rsp_line_number),
      .rsp_contains_pattern(rsp_contains_pattern),
      .rsp_selected        (rsp_selected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #4 clock = ~clock;

   // Mirror of the filter state used to predict each line report.
   byte_type    pat_mem [PATTERN_DEPTH];
   byte_type    text_window [PATTERN_DEPTH];
   int unsigned line_len = 0;
   bit          line_hit = 1'b0;
   line_type    line_no = 1;
   data_type    cfg_len = '0;
   bit          cfg_fold = 1'b0;
   bit          cfg_inv = 1'b0;

   line_report_type pending_reports[$];
   byte_type motif[$];
   stim_row_type directed_rows[$];

   int  errors = 0;
   int  random_items = 0;
   int  reports_seen = 0;
   int  hits_seen = 0;
   int  selected_seen = 0;
   int  settings_used = 0;
   int  hold_requests = 0;
   bit  send_steady = 1'b0;
   longint cycle_count = 0;

   // Idle length: mostly none, some short, a few long.
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic byte_type lower_ascii(input byte_type c, input bit en);
      if (en && c >= "A" && c <= "Z") return c + 8'h20;
      return c;
   endfunction

   function automatic bit is_letter(input byte_type c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // Pattern length in force: clamped, and cut at the first zero byte.
   function automatic int unsigned active_length();
      int unsigned n;
      n = (cfg_len > PATTERN_DEPTH) ? PATTERN_DEPTH : cfg_len;
      for (int unsigned i = 0; i < n; i++) begin
         if (pat_mem[i] == lsf_pkg::NUL_BYTE) return i;
      end
      return n;
   endfunction

   task automatic clear_line();
      foreach (text_window[i]) text_window[i] = '0;
      line_len = 0;
      line_hit = 1'b0;
   endtask

   // Report the pending line, if there is one, and advance the counter.
   task automatic close_line(output bit produced, output line_report_type rep);
      bit hit;
      produced = 1'b0;
      rep = '{default: '0};
      if (line_len == 0) return;
      hit = line_hit || (active_length() == 0);
      rep.line_number = line_no;
      rep.contains = hit;
      rep.selected = hit ^ cfg_inv;
      produced = 1'b1;
      if (line_no != '1) line_no++;
      clear_line();
   endtask

   // Shift a text byte into the window and compare the newest bytes with the pattern.
   task automatic absorb_text(input byte_type c);
      int unsigned len;
      bit same;
      for (int i = 0; i < PATTERN_DEPTH - 1; i++) text_window[i] = text_window[i + 1];
      text_window[PATTERN_DEPTH - 1] = c;
      if (line_len < PATTERN_DEPTH) line_len++;
      len = active_length();
      if (len == 0 || line_len < len) return;
      same = 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
         if (lower_ascii(text_window[PATTERN_DEPTH - len + i], cfg_fold) !=
             lower_ascii(pat_mem[i], cfg_fold)) same = 1'b0;
      end
      if (same) line_hit = 1'b1;
   endtask

   // Predicted effect of one accepted request transfer.
   task automatic predict_step(input cmd_type c, input byte_type v,
                               input pos_type p, output bit produced,
                               output line_report_type rep);
      produced = 1'b0;
      rep = '{default: '0};
      if (c == lsf_pkg::CMD_LOAD) begin
         pat_mem[p] = v;
      end else if (c == lsf_pkg::CMD_TEXT && v != lsf_pkg::NUL_BYTE) begin
         if (v == lsf_pkg::NEWLINE_BYTE) close_line(produced, rep);
         else absorb_text(v);
      end else if (c != CMD_UNUSED) begin
         // End of text, or a text byte of zero: flush and restart numbering.
         close_line(produced, rep);
         clear_line();
         line_no = 1;
      end
   endtask

   // Offer one request and wait for its transfer.
   task automatic transfer_item(input cmd_type c, input byte_type v, input pos_type p);
      int unsigned gap;
      gap = send_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_byte_value <= v;
      req_pattern_position <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue(input cmd_type c, input byte_type v, input pos_type p);
      bit produced;
      line_report_type rep;
      transfer_item(c, v, p);
      predict_step(c, v, p, produced, rep);
      if (produced) pending_reports.push_back(rep);
      if (c != CMD_UNUSED) random_items++;
   endtask

   // Stop offering, wait for every expected report, then let the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input idx_type idx, input data_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         lsf_pkg::REG_PATTERN_LENGTH: cfg_len = val;
         lsf_pkg::REG_CASE_FOLD:      cfg_fold = val[0];
         lsf_pkg::REG_INVERT_SEL:     cfg_inv = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic stim_row_type op_row(input cmd_type c, input byte_type v,
                                           input pos_type p);
      stim_row_type r;
      r = '{default: '0};
      r.cmd = c;
      r.value = v;
      r.pos = p;
      return r;
   endfunction

   function automatic stim_row_type report_row(input cmd_type c, input byte_type v,
                                               input line_type n, input bit hit,
                                               input bit sel);
      stim_row_type r;
      r = op_row(c, v, '0);
      r.typed = 1'b1;
      r.typed_report.line_number = n;
      r.typed_report.contains = hit;
      r.typed_report.selected = sel;
      return r;
   endfunction

   function automatic stim_row_type reg_row(input idx_type idx, input data_type val);
      stim_row_type r;
      r = '{default: '0};
      r.is_reg = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   // Text byte for a random line: mostly small alphabet and pattern bytes, some anything.
   function automatic byte_type pick_text_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return byte_type'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 5));
      if (r < 85 && motif.size() > 0) return motif[$urandom_range(0, motif.size() - 1)];
      if (r < 95) return byte_type'($urandom_range(8'h20, 8'h7E));
      return byte_type'($urandom_range(0, 255));
   endfunction

   // Text byte transfer, now and then preceded by an unused command or a pattern load.
   task automatic issue_text(input byte_type v);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 2) begin
         issue(CMD_UNUSED, byte_type'($urandom_range(0, 255)), pos_type'($urandom_range(0, 63)));
      end else if (r < 3) begin
         issue(lsf_pkg::CMD_LOAD, byte_type'($urandom_range(1, 255)),
               pos_type'($urandom_range(0, 63)));
      end
      issue(lsf_pkg::CMD_TEXT, v, pos_type'($urandom_range(0, 63)));
   endtask

   // One random line: prefix, maybe the pattern with case changes, suffix, terminator.
   task automatic emit_line();
      int unsigned n_pre;
      int unsigned n_post;
      int unsigned r;
      byte_type c;
      n_pre = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(40, 90);
      n_post = $urandom_range(0, 8);
      for (int unsigned i = 0; i < n_pre; i++) issue_text(pick_text_byte());
      if ($urandom_range(0, 1)) begin
         foreach (motif[i]) begin
            c = motif[i];
            if (c == lsf_pkg::NUL_BYTE) break;
            if (is_letter(c) && $urandom_range(0, 99) < (cfg_fold ? 50 : 5)) c = c ^ 8'h20;
            issue_text(c);
         end
      end
      for (int unsigned i = 0; i < n_post; i++) issue_text(pick_text_byte());
      r = $urandom_range(0, 99);
      if (r < 70) begin
         issue(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, pos_type'($urandom_range(0, 63)));
      end else if (r < 80) begin
         repeat ($urandom_range(2, 3)) begin
            issue(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, pos_type'($urandom_range(0, 63)));
         end
      end else if (r < 90) begin
         issue(lsf_pkg::CMD_END, byte_type'($urandom_range(0, 255)),
               pos_type'($urandom_range(0, 63)));
      end else begin
         issue(lsf_pkg::CMD_TEXT, lsf_pkg::NUL_BYTE, pos_type'($urandom_range(0, 63)));
      end
   endtask

   // One random setting: registers, pattern bytes, then lines until the item budget is met.
   task automatic run_phase(input int idx);
      int unsigned plen;
      int unsigned reg_len;
      int unsigned phase_end;
      bit fold;
      bit inv;
      fold = 1'($urandom_range(0, 1));
      inv = 1'($urandom_range(0, 1));
      plen = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 6) : 63;
      case (idx)
         0: begin plen = 64; fold = 1'b1; inv = 1'b0; end
         1: begin plen = 0; fold = 1'b0; inv = 1'b1; end
         2: begin plen = 64; fold = 1'b0; inv = 1'b0; end
         default: ;
      endcase
      reg_len = plen;
      if (idx == 2) reg_len = 127;
      else if (idx > 2 && $urandom_range(0, 99) < 15) reg_len = $urandom_range(plen, 64);
      motif.delete();
      for (int unsigned i = 0; i < plen; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            motif.push_back(byte_type'($urandom_range(1, 255)));
         end else begin
            motif.push_back(byte_type'(($urandom_range(0, 1) ? "a" : "A") +
                                       $urandom_range(0, 5)));
         end
      end
      if (plen > 0 && $urandom_range(0, 9) == 0) begin
         motif[$urandom_range(0, plen - 1)] = lsf_pkg::NUL_BYTE;
      end

      settle();
      write_reg(lsf_pkg::REG_PATTERN_LENGTH, data_type'(reg_len));
      write_reg(lsf_pkg::REG_CASE_FOLD, data_type'(fold));
      write_reg(lsf_pkg::REG_INVERT_SEL, data_type'(inv));
      settings_used++;
      foreach (motif[i]) issue(lsf_pkg::CMD_LOAD, motif[i], pos_type'(i));

      // In one phase the receiver holds off for a long time while requests keep coming.
      send_steady = (idx == 3) || ($urandom_range(0, 99) < 20);
      if (idx == 3) hold_requests++;
      phase_end = random_items + PHASE_ITEMS;
      while (random_items < phase_end) emit_line();
   endtask

   // Compare one response transfer with the oldest expected report.
   task automatic check_report();
      line_report_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t: response with nothing expected: line %0d contains %0b selected %0b",
                  $time, rsp_line_number, rsp_contains_pattern, rsp_selected);
         errors++;
         return;
      end
      want = pending_reports.pop_front();
      reports_seen++;
      if (rsp_contains_pattern) hits_seen++;
      if (rsp_selected) selected_seen++;
      if (rsp_line_number !== want.line_number) begin
         $display("%0t: line_number expected %0d actual %0d",
                  $time, want.line_number, rsp_line_number);
         errors++;
      end
      if (rsp_contains_pattern !== want.contains) begin
         $display("%0t: contains_pattern expected %0b actual %0b (line %0d)",
                  $time, want.contains, rsp_contains_pattern, want.line_number);
         errors++;
      end
      if (rsp_selected !== want.selected) begin
         $display("%0t: selected expected %0b actual %0b (line %0d)",
                  $time, want.selected, rsp_selected, want.line_number);
         errors++;
      end
   endtask

   // Response side: check each transfer, then decide the next ready value.
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int holds_taken = 0;
   bit recv_steady = 1'b0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_report();
      if ($urandom_range(0, 299) == 0) recv_steady = ~recv_steady;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!recv_steady && $urandom_range(0, 99) < 25) stall_left = idle_gap();
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin
      stim_row_type row;
      bit produced;
      line_report_type rep;
      int phase;

      foreach (pat_mem[i]) pat_mem[i] = '0;
      clear_line();

      // Empty pattern after reset: every non-empty line is reported and selected.
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "a", 6'd0));
      directed_rows.push_back(report_row(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, 1, 1'b1,
                                         1'b1));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, 6'd0));
      directed_rows.push_back(op_row(CMD_UNUSED, 8'hFF, 6'h3F));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, 8'hFF, 6'h3F));
      directed_rows.push_back(report_row(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, 2, 1'b1,
                                         1'b1));
      // A zero text byte ends the text; a bare end then produces nothing.
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "b", 6'd0));
      directed_rows.push_back(report_row(lsf_pkg::CMD_TEXT, lsf_pkg::NUL_BYTE, 3, 1'b1, 1'b1));
      directed_rows.push_back(op_row(lsf_pkg::CMD_END, lsf_pkg::NUL_BYTE, 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "c", 6'd0));
      directed_rows.push_back(report_row(lsf_pkg::CMD_END, 8'hFF, 1, 1'b1, 1'b1));
      // Pattern "Ab" ended by a zero byte, with the length register at its maximum.
      directed_rows.push_back(op_row(lsf_pkg::CMD_LOAD, "A", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_LOAD, "b", 6'd1));
      directed_rows.push_back(op_row(lsf_pkg::CMD_LOAD, lsf_pkg::NUL_BYTE, 6'd2));
      directed_rows.push_back(op_row(lsf_pkg::CMD_LOAD, 8'hFF, 6'h3F));
      directed_rows.push_back(reg_row(lsf_pkg::REG_PATTERN_LENGTH, 7'd127));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "x", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "A", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "b", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, 6'd0));
      // Case folding, and inversion switched on in the middle of a line.
      directed_rows.push_back(reg_row(lsf_pkg::REG_CASE_FOLD, 7'd1));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "a", 6'd0));
      directed_rows.push_back(reg_row(lsf_pkg::REG_INVERT_SEL, 7'd1));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "B", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "z", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_END, lsf_pkg::NUL_BYTE, 6'd0));
      // Length zero again: empty pattern, inverted.
      directed_rows.push_back(reg_row(lsf_pkg::REG_PATTERN_LENGTH, 7'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, "q", 6'd0));
      directed_rows.push_back(op_row(lsf_pkg::CMD_TEXT, lsf_pkg::NEWLINE_BYTE, 6'd0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_reg) begin
            settle();
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            transfer_item(row.cmd, row.value, row.pos);
            predict_step(row.cmd, row.value, row.pos, produced, rep);
            if (produced) pending_reports.push_back(row.typed ? row.typed_report : rep);
         end
      end

      // Random part: write every pattern position once, then run settings in turn.
      random_items = 0;
      settle();
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
         issue(lsf_pkg::CMD_LOAD, ($urandom_range(0, 3) == 0) ?
                                  byte_type'($urandom_range(1, 255)) :
                                  byte_type'($urandom_range("a", "z")), pos_type'(p));
      end
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         run_phase(phase);
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4 * DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d directed rows, %0d random transfers and %0d register settings.",
               directed_rows.size(), random_items, settings_used);
      $display("Checked %0d line reports: %0d contained the pattern, %0d were selected.",
               reports_seen, hits_seen, selected_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[files.f]
sv/lsf_pkg.sv
sv/lsf_front.sv
sv/lsf_queue.sv
sv/lsf_match.sv
sv/lsf_report.sv
sv/line_substring_filter.sv
sv/lsf_checker.sv
test/line_substring_filter_tb.sv
